// ----- rtl/tsb_pkg.sv -----
package tsb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CODE_WIDTH      = 16;
  localparam int MANT_BITS       = 30;
  localparam int UNIT_SHIFT      = 14;

  typedef struct packed {
    logic signed [CODE_WIDTH-1:0] tangent_x;
    logic signed [CODE_WIDTH-1:0] tangent_y;
    logic signed [CODE_WIDTH-1:0] tangent_z;
    logic signed [CODE_WIDTH-1:0] bitangent_x;
    logic signed [CODE_WIDTH-1:0] bitangent_y;
    logic signed [CODE_WIDTH-1:0] bitangent_z;
    logic                         degenerate;
  } result_t;

endpackage

// ----- rtl/triangle_tangent_basis.sv -----
// channel   direction  handshake            payload
// vertex    in         push / full          pos_x pos_y pos_z tex_s tex_t
// result    out        pop / empty          tangent_x..z bitangent_x..z degenerate
//
// First and second corners of a triangle are held in registers; the third is queued.
// The back end forms its 14 products on a radix-16 multiplier, then for each vector loads,
// scales, squares and sums, takes the integer root and divides each component by it;
// when the determinant is zero it skips the vector steps and flags the result degenerate.
// Synchronous reset empties both queues and returns the corner count to the first corner.
// full rises when the delta queue is full; a stalled result waits in the output queue.
module triangle_tangent_basis #(
  parameter int COORD_WIDTH = tsb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_s,
  input  logic signed [COORD_WIDTH-1:0] tex_t,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [15:0]            tangent_x,
  output logic signed [15:0]            tangent_y,
  output logic signed [15:0]            tangent_z,
  output logic signed [15:0]            bitangent_x,
  output logic signed [15:0]            bitangent_y,
  output logic signed [15:0]            bitangent_z,
  output logic                          degenerate
);

  localparam int QW = 10 * (COORD_WIDTH + 1);
  localparam int RW = $bits(tsb_pkg::result_t);

  logic             fq_push;
  logic             fq_full;
  logic [QW-1:0]    fq_wdata;
  logic             fq_pop;
  logic             fq_empty;
  logic [QW-1:0]    fq_rdata;
  logic             oq_push;
  logic             oq_full;
  tsb_pkg::result_t oq_wdata;
  logic [RW-1:0]    oq_rdata;
  tsb_pkg::result_t res;

  tsb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z),
    .tex_s  (tex_s),
    .tex_t  (tex_t),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_wdata)
  );

  tsb_fifo #(.WIDTH(QW), .DEPTH(tsb_pkg::QUEUE_DEPTH)) u_delta_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wdata),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  tsb_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (fq_empty),
    .in_pop   (fq_pop),
    .in_data  (fq_rdata),
    .out_full (oq_full),
    .out_push (oq_push),
    .out_data (oq_wdata)
  );

  tsb_fifo #(.WIDTH(RW), .DEPTH(tsb_pkg::QUEUE_DEPTH)) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .full  (oq_full),
    .wdata (oq_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata)
  );

  assign res         = tsb_pkg::result_t'(oq_rdata);
  assign tangent_x   = res.tangent_x;
  assign tangent_y   = res.tangent_y;
  assign tangent_z   = res.tangent_z;
  assign bitangent_x = res.bitangent_x;
  assign bitangent_y = res.bitangent_y;
  assign bitangent_z = res.bitangent_z;
  assign degenerate  = res.degenerate;

endmodule

// ----- rtl/tsb_fifo.sv -----
module tsb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tsb_front.sv -----
module tsb_front #(
  parameter int COORD_WIDTH = tsb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_s,
  input  logic signed [COORD_WIDTH-1:0] tex_t,
  output logic                          q_push,
  input  logic                          q_full,
  output logic [10*(COORD_WIDTH+1)-1:0] q_data
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;

  logic signed [W-1:0]  e_pos [3];
  logic signed [W-1:0]  f_pos [3];
  logic signed [W-1:0]  e_tex [2];
  logic signed [W-1:0]  f_tex [2];
  logic [1:0]           corner_count;
  logic signed [W-1:0]  g_pos [3];
  logic signed [W-1:0]  g_tex [2];
  logic signed [DW-1:0] delta [10];
  logic                 take;

  assign full  = q_full;
  assign take  = push && !q_full;
  assign g_pos[0] = pos_x;
  assign g_pos[1] = pos_y;
  assign g_pos[2] = pos_z;
  assign g_tex[0] = tex_s;
  assign g_tex[1] = tex_t;
  assign q_push = take && (corner_count == 2'd2);

  // order: p xyz, q xyz, s1, t1, s2, t2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      delta[c]     = {f_pos[c][W-1], f_pos[c]} - {e_pos[c][W-1], e_pos[c]};
      delta[3 + c] = {g_pos[c][W-1], g_pos[c]} - {e_pos[c][W-1], e_pos[c]};
    end
    delta[6] = {f_tex[0][W-1], f_tex[0]} - {e_tex[0][W-1], e_tex[0]};
    delta[7] = {f_tex[1][W-1], f_tex[1]} - {e_tex[1][W-1], e_tex[1]};
    delta[8] = {g_tex[0][W-1], g_tex[0]} - {e_tex[0][W-1], e_tex[0]};
    delta[9] = {g_tex[1][W-1], g_tex[1]} - {e_tex[1][W-1], e_tex[1]};
  end

  for (genvar i = 0; i < 10; i++) begin : g_pack
    assign q_data[i*DW +: DW] = delta[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (take) begin
      unique case (corner_count)
        2'd1: begin
          f_pos        <= g_pos;
          f_tex        <= g_tex;
          corner_count <= 2'd2;
        end
        2'd2: begin
          corner_count <= 2'd0;
        end
        default: begin
          e_pos        <= g_pos;
          e_tex        <= g_tex;
          corner_count <= 2'd1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/tsb_back.sv -----
module tsb_back #(
  parameter int COORD_WIDTH = tsb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_empty,
  output logic                          in_pop,
  input  logic [10*(COORD_WIDTH+1)-1:0] in_data,
  input  logic                          out_full,
  output logic                          out_push,
  output tsb_pkg::result_t              out_data
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int NW    = 2 * DW + 1;
  localparam int MW    = (NW > 40) ? NW : 40;
  localparam int NSTEP = (DW + 3) / 4;
  localparam int MBW   = NSTEP * 4;
  localparam int PW    = MBW + DW;
  localparam int CNW   = $clog2(NSTEP) + 1;
  localparam int MB    = tsb_pkg::MANT_BITS;
  localparam int US    = tsb_pkg::UNIT_SHIFT;
  localparam int CW    = tsb_pkg::CODE_WIDTH;
  localparam int RW    = MB + US + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MLOAD  = 4'd1;
  localparam logic [3:0] S_MSTEP  = 4'd2;
  localparam logic [3:0] S_MDONE  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_NLOAD  = 4'd5;
  localparam logic [3:0] S_NSHIFT = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_ACC    = 4'd8;
  localparam logic [3:0] S_SQRT   = 4'd9;
  localparam logic [3:0] S_DLOAD  = 4'd10;
  localparam logic [3:0] S_DSTEP  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]           state;
  logic signed [DW-1:0] d [10];
  logic [3:0]           job;
  logic [DW-1:0]        ma;
  logic [MBW-1:0]       mb;
  logic                 psign;
  logic [PW-1:0]        acc;
  logic [CNW-1:0]       cnt;
  logic signed [NW-1:0] nacc;
  logic signed [NW-1:0] det;
  logic signed [NW-1:0] nt [3];
  logic signed [NW-1:0] nb [3];
  logic                 degen;
  logic                 vec;
  logic [MW-1:0]        m [3];
  logic                 neg [3];
  logic [1:0]           idx;
  logic [2*MB-1:0]      prod2;
  logic [63:0]          sum;
  logic [63:0]          rv;
  logic [63:0]          sres;
  logic [63:0]          sbit;
  logic [RW-1:0]        rem;
  logic [MB-2:0]        quot;
  logic [3:0]           k;
  logic [CW-1:0]        rcode [6];

  logic signed [DW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic [DW-1:0]        abs_a;
  logic [DW-1:0]        abs_b;
  logic signed [NW-1:0] prod_s;
  logic signed [NW-1:0] fin;
  logic [MW-1:0]        orv;
  logic [63:0]          sum_n;
  logic [63:0]          strial;
  logic [RW-1:0]        trial;
  logic [MB-2:0]        quot_n;
  logic                 fits;
  logic [CW-1:0]        code;
  logic [MB-1:0]        m_sel;
  logic [2:0]           widx;

  for (genvar i = 0; i < 10; i++) begin : g_unpack
    assign d[i] = in_data[i*DW +: DW];
  end

  // the queue head feeds the products, so it is released once they are all done
  assign in_pop   = (state == S_CHECK);
  assign out_push = (state == S_OUT);

  // product list: det, then tangent per axis, then bitangent per axis
  always_comb begin
    unique case (job)
      4'd0:    begin op_a = d[6]; op_b = d[9]; end
      4'd1:    begin op_a = d[8]; op_b = d[7]; end
      4'd2:    begin op_a = d[9]; op_b = d[0]; end
      4'd3:    begin op_a = d[7]; op_b = d[3]; end
      4'd4:    begin op_a = d[9]; op_b = d[1]; end
      4'd5:    begin op_a = d[7]; op_b = d[4]; end
      4'd6:    begin op_a = d[9]; op_b = d[2]; end
      4'd7:    begin op_a = d[7]; op_b = d[5]; end
      4'd8:    begin op_a = d[6]; op_b = d[3]; end
      4'd9:    begin op_a = d[8]; op_b = d[0]; end
      4'd10:   begin op_a = d[6]; op_b = d[4]; end
      4'd11:   begin op_a = d[8]; op_b = d[1]; end
      4'd12:   begin op_a = d[6]; op_b = d[5]; end
      4'd13:   begin op_a = d[8]; op_b = d[2]; end
      default: begin op_a = '0;   op_b = '0;   end
    endcase
  end

  always_comb begin
    abs_a  = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
    abs_b  = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
    prod_s = psign ? -$signed({1'b0, acc[2*DW-1:0]}) : $signed({1'b0, acc[2*DW-1:0]});
    fin    = nacc - prod_s;
    orv    = m[0] | m[1] | m[2];
    sum_n  = sum + {{(64 - 2*MB){1'b0}}, prod2};
    strial = sres + sbit;
    m_sel  = m[idx][MB-1:0];
    trial  = {{(RW - MB - 1){1'b0}}, sres[MB:0]} << k;
    fits   = (rem >= trial);
    quot_n = quot;
    if (fits) begin
      quot_n[k] = 1'b1;
    end
    code   = CW'(neg[idx] ? -{1'b0, quot_n} : {1'b0, quot_n});
    widx   = (vec ? 3'd3 : 3'd0) + {1'b0, idx};
  end

  always_comb begin
    out_data.tangent_x   = degen ? '0 : rcode[0];
    out_data.tangent_y   = degen ? '0 : rcode[1];
    out_data.tangent_z   = degen ? '0 : rcode[2];
    out_data.bitangent_x = degen ? '0 : rcode[3];
    out_data.bitangent_y = degen ? '0 : rcode[4];
    out_data.bitangent_z = degen ? '0 : rcode[5];
    out_data.degenerate  = degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!in_empty) begin
            degen <= 1'b0;
            job   <= 4'd0;
            state <= S_MLOAD;
          end
        end
        S_MLOAD: begin
          ma    <= abs_a;
          mb    <= MBW'(abs_b);
          psign <= op_a[DW-1] ^ op_b[DW-1];
          acc   <= '0;
          cnt   <= CNW'(NSTEP - 1);
          state <= S_MSTEP;
        end
        S_MSTEP: begin
          // radix-16 shift-add, top digit first
          acc <= (acc << 4) + PW'(ma * mb[MBW-1 -: 4]);
          mb  <= mb << 4;
          if (cnt == '0) begin
            state <= S_MDONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MDONE: begin
          if (!job[0]) begin
            nacc <= prod_s;
          end else begin
            case (job[3:1])
              3'd0: det   <= fin;
              3'd1: nt[0] <= fin;
              3'd2: nt[1] <= fin;
              3'd3: nt[2] <= fin;
              3'd4: nb[0] <= fin;
              3'd5: nb[1] <= fin;
              default: nb[2] <= fin;
            endcase
          end
          if (job == 4'd13) begin
            state <= S_CHECK;
          end else begin
            job   <= job + 1'b1;
            state <= S_MLOAD;
          end
        end
        S_CHECK: begin
          if (det == '0) begin
            degen <= 1'b1;
            state <= S_OUT;
          end else begin
            vec   <= 1'b0;
            state <= S_NLOAD;
          end
        end
        S_NLOAD: begin
          for (int c = 0; c < 3; c++) begin
            if (vec) begin
              m[c]   <= MW'(nb[c][NW-1] ? NW'(-nb[c]) : NW'(nb[c]));
              neg[c] <= nb[c][NW-1] ^ det[NW-1];
            end else begin
              m[c]   <= MW'(nt[c][NW-1] ? NW'(-nt[c]) : NW'(nt[c]));
              neg[c] <= nt[c][NW-1] ^ det[NW-1];
            end
          end
          state <= S_NSHIFT;
        end
        S_NSHIFT: begin
          // common truncating shift until the largest fits the mantissa
          if (orv == '0) begin
            degen <= 1'b1;
            state <= S_OUT;
          end else if (|orv[MW-1:MB+8]) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] >> 8;
          end else if (|orv[MW-1:MB]) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] >> 1;
          end else begin
            idx   <= 2'd0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod2 <= m_sel * m_sel;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_n;
          if (idx == 2'd2) begin
            rv    <= sum_n;
            sres  <= '0;
            sbit  <= 64'd1 << 62;
            state <= S_SQRT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ;
          end
        end
        S_SQRT: begin
          if (rv >= strial) begin
            rv   <= rv - strial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit == 64'd1) begin
            idx   <= 2'd0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          rem   <= RW'({m_sel, {US{1'b0}}}) + RW'(sres[MB:1]);
          quot  <= '0;
          k     <= 4'(US);
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          if (fits) begin
            rem <= rem - trial;
          end
          quot <= quot_n;
          if (k == 4'd0) begin
            rcode[widx] <= code;
            if (idx == 2'd2) begin
              if (!vec) begin
                vec   <= 1'b1;
                state <= S_NLOAD;
              end else begin
                state <= S_OUT;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DLOAD;
            end
          end else begin
            k <= k - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/tsb_checker.sv -----
module tsb_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] tangent_x,
  input logic signed [15:0] tangent_y,
  input logic signed [15:0] tangent_z,
  input logic signed [15:0] bitangent_x,
  input logic signed [15:0] bitangent_y,
  input logic signed [15:0] bitangent_z,
  input logic               degenerate
);

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(tangent_x) && $stable(bitangent_z)
      && $stable(degenerate))
    else $error("waiting result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && degenerate |-> tangent_x == 0 && tangent_y == 0 && tangent_z == 0
      && bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)
    else $error("degenerate result with nonzero vector");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> tangent_x <= 16'sd16384 && tangent_x >= -16'sd16384
      && bitangent_x <= 16'sd16384 && bitangent_x >= -16'sd16384)
    else $error("component beyond unit range");

endmodule

bind triangle_tangent_basis tsb_checker u_tsb_checker (.*);

// ----- tb/sv/tb_triangle_tangent_basis.sv -----
module tb_triangle_tangent_basis;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0] coord_t;

  typedef struct {
    coord_t px, py, pz, ts, tt;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  coord_t pos_x = '0, pos_y = '0, pos_z = '0, tex_s = '0, tex_t = '0;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic signed [15:0] bitangent_x, bitangent_y, bitangent_z;
  logic degenerate;

  triangle_tangent_basis dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_s(tex_s), .tex_t(tex_t),
    .empty(empty), .pop(pop),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
    .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_t pending_verts[$];
  tsb_pkg::result_t expected_basis[$];
  int mismatches = 0;

  // Predictor state: corners E and F, corner counter
  coord_t corner_pos[6];
  coord_t corner_tex[4];
  logic [1:0] corner_cnt = 2'd0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void add_vertex(input vertex_t v);
    pending_verts.insert(pending_verts.size(), v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale to a 30-bit mantissa, then divide by the integer length; zero vector -> 0
  function automatic bit to_unit(input wide_t a, input wide_t b, input wide_t c,
                                 output logic [47:0] codes);
    logic [127:0] mg[3];
    logic [63:0] mm[3];
    logic [63:0] sum, len, q;
    logic [15:0] cd;
    bit ng[3];
    int top, sh;
    top = 0;
    mg[0] = a < 0 ? -a : a; ng[0] = a < 0;
    mg[1] = b < 0 ? -b : b; ng[1] = b < 0;
    mg[2] = c < 0 ? -c : c; ng[2] = c < 0;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 128; i++)
        if (mg[k][i] && i + 1 > top) top = i + 1;
    codes = '0;
    if (top == 0) return 0;
    sh = top > tsb_pkg::MANT_BITS ? top - tsb_pkg::MANT_BITS : 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mm[k] = 64'(mg[k] >> sh);
      sum = sum + mm[k] * mm[k];
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mm[k] * 64'd16384 + len / 2) / len;
      cd = ng[k] ? 16'(-q) : 16'(q);
      codes[47 - 16*k -: 16] = cd;
    end
    return 1;
  endfunction

  function automatic bit predict_corner(input vertex_t v, output tsb_pkg::result_t r);
    wide_t p[3], q[3], tg[3], bt[3];
    wide_t s1, t1, s2, t2, det;
    coord_t g[3];
    logic [47:0] ut, ub;
    bit ok;
    g[0] = v.px; g[1] = v.py; g[2] = v.pz;
    r = '0;
    if (corner_cnt != 2'd2) begin
      automatic int slot = corner_cnt == 2'd1 ? 1 : 0;
      for (int k = 0; k < 3; k++) corner_pos[slot*3 + k] = g[k];
      corner_tex[slot*2] = v.ts;
      corner_tex[slot*2 + 1] = v.tt;
      corner_cnt = 2'(slot + 1);
      return 0;
    end
    corner_cnt = 2'd0;
    for (int k = 0; k < 3; k++) begin
      p[k] = wide_t'(corner_pos[3+k]) - wide_t'(corner_pos[k]);
      q[k] = wide_t'(g[k]) - wide_t'(corner_pos[k]);
    end
    s1 = wide_t'(corner_tex[2]) - wide_t'(corner_tex[0]);
    t1 = wide_t'(corner_tex[3]) - wide_t'(corner_tex[1]);
    s2 = wide_t'(v.ts) - wide_t'(corner_tex[0]);
    t2 = wide_t'(v.tt) - wide_t'(corner_tex[1]);
    det = s1 * t2 - s2 * t1;
    ok = det != 0;
    if (ok) begin
      for (int k = 0; k < 3; k++) begin
        tg[k] = t2 * p[k] - t1 * q[k];
        bt[k] = s1 * q[k] - s2 * p[k];
        if (det < 0) begin
          tg[k] = -tg[k];
          bt[k] = -bt[k];
        end
      end
      ok = to_unit(tg[0], tg[1], tg[2], ut);
      if (ok) ok = to_unit(bt[0], bt[1], bt[2], ub);
    end
    if (ok) begin
      {r.tangent_x, r.tangent_y, r.tangent_z} = ut;
      {r.bitangent_x, r.bitangent_y, r.bitangent_z} = ub;
    end
    r.degenerate = !ok;
    return 1;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      1, 2: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
    endcase
  endfunction

  function automatic vertex_t mk(input coord_t x, y, z, s, t);
    vertex_t v;
    v.px = x; v.py = y; v.pz = z; v.ts = s; v.tt = t;
    return v;
  endfunction

  // Driver: bursts of transfers separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      tsb_pkg::result_t r;
      if (predict_corner(pending_verts[0], r))
        expected_basis.insert(expected_basis.size(), r);
      void'(pending_verts.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst || pending_verts.size() == 0) begin
      push <= 1'b0;
    end else if (burst_left > 0 || gap_left == 0) begin
      if (burst_left == 0) burst_left = $urandom_range(1, 12);
      burst_left--;
      if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      push <= 1'b1;
      pos_x <= pending_verts[0].px; pos_y <= pending_verts[0].py;
      pos_z <= pending_verts[0].pz; tex_s <= pending_verts[0].ts;
      tex_t <= pending_verts[0].tt;
    end else begin
      gap_left--;
      push <= 1'b0;
    end
  end

  // Receiver: mode rotates through always ready, periodic, random
  int rx_cyc = 0;
  always @(negedge clk) begin
    rx_cyc++;
    case ((rx_cyc >> 8) % 3)
      0: pop <= 1'b1;
      1: pop <= (rx_cyc % 11) < 3;
      default: pop <= $urandom_range(0, 3) != 0;
    endcase
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_basis.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        tsb_pkg::result_t e;
        e = expected_basis.pop_front();
        if (tangent_x !== e.tangent_x) report("tangent_x", tangent_x, e.tangent_x);
        if (tangent_y !== e.tangent_y) report("tangent_y", tangent_y, e.tangent_y);
        if (tangent_z !== e.tangent_z) report("tangent_z", tangent_z, e.tangent_z);
        if (bitangent_x !== e.bitangent_x) report("bitangent_x", bitangent_x, e.bitangent_x);
        if (bitangent_y !== e.bitangent_y) report("bitangent_y", bitangent_y, e.bitangent_y);
        if (bitangent_z !== e.bitangent_z) report("bitangent_z", bitangent_z, e.bitangent_z);
        if (degenerate !== e.degenerate) report("degenerate", degenerate, e.degenerate);
      end
    end
  end

  // Watchdog: cycles with work outstanding but no transfer on either side
  int stuck = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)
        || (pending_verts.size() == 0 && expected_basis.size() == 0)) begin
      stuck <= 0;
    end else if (stuck >= 20000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;
  localparam coord_t ONE = 32'sh00010000;

  initial begin
    vertex_t a;
    // simple unit triangle
    add_vertex(mk(0, 0, 0, 0, 0));
    add_vertex(mk(ONE, 0, 0, ONE, 0));
    add_vertex(mk(0, ONE, 0, 0, ONE));
    // mirrored texture, negative determinant
    add_vertex(mk(0, 0, 0, 0, 0));
    add_vertex(mk(ONE, 0, 0, -ONE, 0));
    add_vertex(mk(0, 0, ONE, 0, ONE));
    // zero determinant: collinear texture coordinates
    add_vertex(mk(0, 0, 0, ONE, ONE));
    add_vertex(mk(ONE, 5, 7, ONE, ONE));
    add_vertex(mk(3, ONE, 9, ONE, ONE));
    // zero-length vectors: all positions equal, texture fine
    add_vertex(mk(42, -42, 7, 0, 0));
    add_vertex(mk(42, -42, 7, ONE, 0));
    add_vertex(mk(42, -42, 7, 0, ONE));
    // field extremes
    add_vertex(mk(CMIN, CMIN, CMIN, CMIN, CMIN));
    add_vertex(mk(CMAX, CMAX, CMAX, CMAX, CMIN));
    add_vertex(mk(CMIN, CMAX, CMIN, CMIN, CMAX));
    add_vertex(mk(CMAX, CMIN, CMAX, CMAX, CMAX));
    add_vertex(mk(CMIN, CMAX, 0, CMIN, CMAX));
    add_vertex(mk(-1, 0, CMAX, CMAX, CMIN));
    for (int i = 0; i < 333; i++) begin
      for (int k = 0; k < 3; k++) begin
        a = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
        // now and then reuse the previous corner to hit degenerate paths
        if (k > 0 && $urandom_range(0, 15) == 0) begin
          a.ts = pending_verts[$].ts;
          a.tt = pending_verts[$].tt;
        end
        if (k > 0 && $urandom_range(0, 15) == 0) begin
          a.px = pending_verts[$].px;
          a.py = pending_verts[$].py;
          a.pz = pending_verts[$].pz;
        end
        add_vertex(a);
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_verts.size() == 0 && expected_basis.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_basis.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
